// ===== sv/lpkt_pkg.sv =====
// ----------------------------------------------------------------------------
// lpkt_pkg
// Shared constants, result codes and helpers for the linear probe key table.
// ----------------------------------------------------------------------------
package lpkt_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int KEY_W       = 64;
  localparam int SLOT_W      = 10;
  localparam int CNT_W       = 11;

  localparam logic [KEY_W-1:0] HASH_MULT  = 64'hff51afd7ed558ccd;
  localparam int               HASH_SHIFT = 33;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_NULL      = 3'd5
  } status_t;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_t;

  // Probe step with wrap from the last slot to slot 0
  function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] s);
    if (s == ADDR_W'(TABLE_DEPTH - 1)) begin
      return '0;
    end
    return s + ADDR_W'(1);
  endfunction

endpackage

// ===== sv/linear_probe_key_table.sv =====
// ----------------------------------------------------------------------------
// linear_probe_key_table
// Set of 64-bit keys in an open-addressed table with linear probing.
// ----------------------------------------------------------------------------
// A request (kind, key) is taken when start is high and busy is low; its one
// result appears on status, slot and occupied_count for a single cycle with
// done high, and must be captured then, as there is no way to hold it off.
// After reset the block sweeps the 1024-entry key memory to zero, one entry
// per cycle, with busy high throughout. A null key answers in the next cycle
// without raising busy. Otherwise an operation first computes the home-slot
// hash, which runs on one shared 32x32 multiplier, then probes slots, one per
// cycle through the key memory read port. A remove then takes each following
// entry of the cluster out, rehashes it and probes again from its home slot
// to place it, until it sees the empty slot that ends the cluster.
// ----------------------------------------------------------------------------
module linear_probe_key_table
  import lpkt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              kind,
  input  logic [KEY_W-1:0]  key,
  output logic              done,
  output logic [2:0]        status,
  output logic [SLOT_W-1:0] slot,
  output logic [CNT_W-1:0]  occupied_count
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_RCHK,
    S_RHASH,
    S_PLACE,
    S_RNEXT
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] clr_cnt;
  kind_t             op_kind;
  logic [KEY_W-1:0]  op_key;
  logic [KEY_W-1:0]  moved;
  logic [ADDR_W-1:0] s;
  logic [ADDR_W-1:0] n;
  logic [ADDR_W-1:0] t;
  logic [CNT_W-1:0]  rn;
  logic [CNT_W-1:0]  occupied;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [KEY_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [KEY_W-1:0]  ram_rdata;

  logic              hash_start;
  logic [KEY_W-1:0]  hash_key;
  logic              hash_done;
  logic [ADDR_W-1:0] hash_slot;

  logic              rd_empty;
  logic              rd_hit;
  logic              probe_last;
  logic              repair_end;
  logic [ADDR_W-1:0] s_inc;

  lpkt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lpkt_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (hash_key),
    .done  (hash_done),
    .slot  (hash_slot)
  );

  assign rd_empty   = (ram_rdata == '0);
  assign rd_hit     = (ram_rdata == op_key);
  assign probe_last = (n == ADDR_W'(TABLE_DEPTH - 1));
  assign repair_end = (rn == CNT_W'(TABLE_DEPTH)) || rd_empty;
  assign s_inc      = next_slot(s);
  assign busy       = (state != S_IDLE);

  // Memory and hash controls. A read issued here returns data next cycle.
  // A read of the entry being written in the same cycle only happens where
  // its data goes unused: after a placement the next cluster read is issued
  // from S_RNEXT.
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = s;
    ram_wdata  = '0;
    ram_raddr  = s;
    hash_start = 1'b0;
    hash_key   = key;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
      end
      S_IDLE: begin
        hash_start = start && (key != '0);
      end
      S_HASH, S_RHASH: begin
        ram_raddr = hash_slot;
      end
      S_PROBE: begin
        if (op_kind == KIND_INSERT) begin
          if (rd_empty) begin
            ram_we    = 1'b1;
            ram_wdata = op_key;
          end else begin
            ram_raddr = s_inc;
          end
        end else begin
          ram_raddr = s_inc;
          if (!rd_empty && rd_hit) begin
            ram_we = 1'b1;
          end
        end
      end
      S_RCHK: begin
        if (!repair_end) begin
          ram_we     = 1'b1;
          ram_waddr  = t;
          hash_start = 1'b1;
          hash_key   = ram_rdata;
        end
      end
      S_PLACE: begin
        if (rd_empty) begin
          ram_we    = 1'b1;
          ram_wdata = moved;
        end else begin
          ram_raddr = s_inc;
        end
      end
      S_RNEXT: begin
        ram_raddr = t;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      occupied <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + ADDR_W'(1);
          if (clr_cnt == ADDR_W'(TABLE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_kind <= kind_t'(kind);
            op_key  <= key;
            if (key == '0) begin
              done           <= 1'b1;
              status         <= ST_NULL;
              slot           <= '0;
              occupied_count <= occupied;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            s     <= hash_slot;
            n     <= '0;
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (op_kind == KIND_INSERT) begin
            if (rd_empty) begin
              done           <= 1'b1;
              status         <= ST_INSERTED;
              slot           <= SLOT_W'(s);
              occupied       <= occupied + CNT_W'(1);
              occupied_count <= occupied + CNT_W'(1);
              state          <= S_IDLE;
            end else if (rd_hit) begin
              done           <= 1'b1;
              status         <= ST_PRESENT;
              slot           <= SLOT_W'(s);
              occupied_count <= occupied;
              state          <= S_IDLE;
            end else if (probe_last) begin
              done           <= 1'b1;
              status         <= ST_FULL;
              slot           <= '0;
              occupied_count <= occupied;
              state          <= S_IDLE;
            end else begin
              s <= s_inc;
              n <= n + ADDR_W'(1);
            end
          end else begin
            if (rd_empty || (!rd_hit && probe_last)) begin
              done           <= 1'b1;
              status         <= ST_NOT_FOUND;
              slot           <= '0;
              occupied_count <= occupied;
              state          <= S_IDLE;
            end else if (rd_hit) begin
              // Slot cleared; result goes out once the cluster is repaired
              status <= ST_REMOVED;
              slot   <= SLOT_W'(s);
              if (occupied != '0) begin
                occupied <= occupied - CNT_W'(1);
              end
              t     <= s_inc;
              rn    <= '0;
              state <= S_RCHK;
            end else begin
              s <= s_inc;
              n <= n + ADDR_W'(1);
            end
          end
        end
        S_RCHK: begin
          if (repair_end) begin
            done           <= 1'b1;
            occupied_count <= occupied;
            state          <= S_IDLE;
          end else begin
            moved <= ram_rdata;
            state <= S_RHASH;
          end
        end
        S_RHASH: begin
          if (hash_done) begin
            s     <= hash_slot;
            n     <= '0;
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          if (rd_empty || probe_last) begin
            t     <= next_slot(t);
            rn    <= rn + CNT_W'(1);
            state <= S_RNEXT;
          end else begin
            s <= s_inc;
            n <= n + ADDR_W'(1);
          end
        end
        S_RNEXT: begin
          state <= S_RCHK;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/lpkt_ram.sv =====
// ----------------------------------------------------------------------------
// lpkt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lpkt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/lpkt_hash.sv =====
// ----------------------------------------------------------------------------
// lpkt_hash
// Home slot hash: xor-shift, 64-bit multiply (low half), xor-shift, low bits.
// One shared 32x32 multiplier over three partial products.
// ----------------------------------------------------------------------------
module lpkt_hash
  import lpkt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [KEY_W-1:0]  key,
  output logic              done,
  output logic [ADDR_W-1:0] slot
);

  logic             run;
  logic [2:0]       phase;
  logic [KEY_W-1:0] x;
  logic [KEY_W-1:0] prod;
  logic [KEY_W-1:0] acc;
  logic [31:0]      op_a;
  logic [31:0]      op_b;
  logic [KEY_W-1:0] mixed;

  // Low 64 bits of x * M = x0*m0 + ((x0*m1 + x1*m0) << 32)
  always_comb begin
    op_a = x[31:0];
    op_b = HASH_MULT[31:0];
    case (phase)
      3'd1: op_b = HASH_MULT[63:32];
      3'd2: begin
        op_a = x[63:32];
        op_b = HASH_MULT[31:0];
      end
      default: ;
    endcase
  end

  assign mixed = acc ^ (acc >> HASH_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      phase <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x     <= key ^ (key >> HASH_SHIFT);
        run   <= 1'b1;
        phase <= '0;
      end else if (run) begin
        prod  <= KEY_W'(op_a) * KEY_W'(op_b);
        phase <= phase + 3'd1;
        case (phase)
          3'd1: acc <= prod;
          3'd2: acc <= acc + {prod[31:0], 32'b0};
          3'd3: acc <= acc + {prod[31:0], 32'b0};
          3'd4: begin
            // power-of-two depth: modulo is the low bits
            slot <= mixed[ADDR_W-1:0];
            done <= 1'b1;
            run  <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== sv/lpkt_checker.sv =====
// ----------------------------------------------------------------------------
// lpkt_checker
// Port-level checks on the linear probe key table, bound to the top level.
// ----------------------------------------------------------------------------
module lpkt_checker
  import lpkt_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              kind,
  input logic [KEY_W-1:0]  key,
  input logic              done,
  input logic [2:0]        status,
  input logic [SLOT_W-1:0] slot,
  input logic [CNT_W-1:0]  occupied_count
);

  // A real key keeps the block busy while it searches
  a_key_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (key != '0) |=> busy)
    else $error("request with key taken but busy not raised");

  // A null key answers at once
  a_null_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (key == '0) |=> done && (status == ST_NULL) && (slot == '0))
    else $error("null key request not answered in the next cycle");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status <= ST_NULL))
    else $error("result status out of range");

  // Outcomes that touch no slot report slot zero
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    done && ((status == ST_FULL) || (status == ST_NOT_FOUND) || (status == ST_NULL))
      |-> (slot == '0))
    else $error("nonzero slot on result with no slot");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (occupied_count <= CNT_W'(TABLE_DEPTH)))
    else $error("occupied count beyond table depth");

endmodule

bind linear_probe_key_table lpkt_checker u_lpkt_checker (.*);

// ===== tb/linear_probe_key_table_checker.sv =====
// ----------------------------------------------------------------------------
// linear_probe_key_table_checker
// Watches the request and result ports of the key table and keeps a shadow
// copy of the slot array and occupancy. Every accepted request is applied to
// the shadow table to predict its result, and every done strobe is compared
// field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module linear_probe_key_table_checker
  import lpkt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic              kind,
  input  logic [KEY_W-1:0]  key,
  input  logic              done,
  input  logic [2:0]        status,
  input  logic [SLOT_W-1:0] slot,
  input  logic [CNT_W-1:0]  occupied_count,
  output int                fail_count,
  output int                pending
);

  typedef struct {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  count;
  } table_result_t;

  logic [KEY_W-1:0] shadow_keys [TABLE_DEPTH];
  int               shadow_count;
  table_result_t    predicted_results [$];

  function automatic logic [ADDR_W-1:0] home_of(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] h;
    h = k ^ (k >> HASH_SHIFT);
    h = h * HASH_MULT;
    h = h ^ (h >> HASH_SHIFT);
    return ADDR_W'(h % KEY_W'(TABLE_DEPTH));
  endfunction

  function automatic logic [ADDR_W-1:0] wrap_next(input logic [ADDR_W-1:0] s);
    return (int'(s) == TABLE_DEPTH - 1) ? '0 : s + 1'b1;
  endfunction

  // Applies one request to the shadow table and returns its result
  function automatic table_result_t table_op(input kind_t op, input logic [KEY_W-1:0] k);
    table_result_t     r;
    logic [ADDR_W-1:0] s;
    logic [ADDR_W-1:0] t;
    logic [KEY_W-1:0]  moved;
    bit                found;
    r.status = ST_NULL;
    r.slot   = '0;
    found    = 1'b0;
    if (k == '0) begin
      r.status = ST_NULL;
    end else if (op == KIND_INSERT) begin
      r.status = ST_FULL;
      s = home_of(k);
      for (int n = 0; n < TABLE_DEPTH; n++) begin
        if (shadow_keys[s] == '0) begin
          shadow_keys[s] = k;
          shadow_count++;
          r.status = ST_INSERTED;
          r.slot   = SLOT_W'(s);
          break;
        end
        if (shadow_keys[s] == k) begin
          r.status = ST_PRESENT;
          r.slot   = SLOT_W'(s);
          break;
        end
        s = wrap_next(s);
      end
    end else begin
      s = home_of(k);
      for (int n = 0; n < TABLE_DEPTH; n++) begin
        if (shadow_keys[s] == '0) break;
        if (shadow_keys[s] == k) begin
          found = 1'b1;
          break;
        end
        s = wrap_next(s);
      end
      if (!found) begin
        r.status = ST_NOT_FOUND;
      end else begin
        shadow_keys[s] = '0;
        if (shadow_count > 0) shadow_count--;
        r.status = ST_REMOVED;
        r.slot   = SLOT_W'(s);
        // pull the rest of the cluster out and re-place each entry from home
        t = wrap_next(s);
        for (int n = 0; n < TABLE_DEPTH; n++) begin
          moved = shadow_keys[t];
          if (moved == '0) break;
          shadow_keys[t] = '0;
          s = home_of(moved);
          for (int m = 0; m < TABLE_DEPTH; m++) begin
            if (shadow_keys[s] == '0) begin
              shadow_keys[s] = moved;
              break;
            end
            s = wrap_next(s);
          end
          t = wrap_next(t);
        end
      end
    end
    r.count = CNT_W'(shadow_count);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    table_result_t want;
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++) shadow_keys[i] = '0;
      shadow_count = 0;
      predicted_results.delete();
      fail_count = 0;
    end else begin
      // results first, so a request taken on the same edge queues behind them
      if (done) begin
        if (predicted_results.size() == 0) begin
          $error("result with nothing outstanding: status %0d slot %0d count %0d",
                 status, slot, occupied_count);
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fail_count++;
          end
          if (slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, slot);
            fail_count++;
          end
          if (occupied_count !== want.count) begin
            $error("occupied_count: expected %0d, got %0d", want.count, occupied_count);
            fail_count++;
          end
        end
      end
      if (start && !busy) predicted_results.push_back(table_op(kind_t'(kind), key));
    end
    pending = predicted_results.size();
  end

endmodule

// ===== tb/linear_probe_key_table_tb.sv =====
// ----------------------------------------------------------------------------
// linear_probe_key_table_tb
// Drives insert and remove requests into the key table: a directed set of
// edge keys, then random traffic at moderate load, a fill to a completely
// full table with lookups there, and a partial drain. Results are checked by
// the checker module; this top makes the stimulus and prints the verdict.
// ----------------------------------------------------------------------------
module linear_probe_key_table_tb;
  import lpkt_pkg::*;

  logic              clk   = 1'b0;
  logic              rst   = 1'b1;
  logic              start = 1'b0;
  kind_t             kind  = KIND_INSERT;
  logic [KEY_W-1:0]  key   = '0;
  logic              busy;
  logic              done;
  logic [2:0]        status;
  logic [SLOT_W-1:0] slot;
  logic [CNT_W-1:0]  occupied_count;
  int                fail_count;
  int                pending;
  logic              req_fire = 1'b0;

  logic [KEY_W-1:0]  held_keys [$];
  int                calm_left = 0;

  linear_probe_key_table u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .kind           (kind),
    .key            (key),
    .done           (done),
    .status         (status),
    .slot           (slot),
    .occupied_count (occupied_count)
  );

  linear_probe_key_table_checker u_chk (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .kind           (kind),
    .key            (key),
    .done           (done),
    .status         (status),
    .slot           (slot),
    .occupied_count (occupied_count),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // high at a falling edge when the request was taken at the rising edge before
  always @(posedge clk) req_fire <= start && !busy && !rst;

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_req(input kind_t op, input logic [KEY_W-1:0] k);
    int gap;
    int r;
    gap = 0;
    if (calm_left > 0) begin
      calm_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 4) calm_left = $urandom_range(20, 40);
      else if (r < 50) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    kind  <= op;
    key   <= k;
    do @(negedge clk); while (!req_fire);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    logic [KEY_W-1:0] k;
    do k = {$urandom, $urandom}; while (k == '0);
    return k;
  endfunction

  task automatic insert_new();
    logic [KEY_W-1:0] k;
    k = rand_key();
    send_req(KIND_INSERT, k);
    if (held_keys.size() < TABLE_DEPTH) held_keys.push_back(k);
  endtask

  task automatic remove_held();
    int               idx;
    logic [KEY_W-1:0] k;
    idx = $urandom_range(0, held_keys.size() - 1);
    k = held_keys[idx];
    held_keys.delete(idx);
    send_req(KIND_REMOVE, k);
  endtask

  task automatic insert_held();
    send_req(KIND_INSERT, held_keys[$urandom_range(0, held_keys.size() - 1)]);
  endtask

  initial begin
    #400_000_000;
    $display("[linear_probe_key_table] ERROR");
    $finish;
  end

  initial begin
    int r;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // directed: null keys, empty-table miss, extreme keys, repeats, re-add
    send_req(KIND_INSERT, '0);
    send_req(KIND_REMOVE, '0);
    send_req(KIND_REMOVE, 64'd5);
    send_req(KIND_INSERT, '1);
    send_req(KIND_INSERT, 64'd1);
    send_req(KIND_INSERT, 64'h8000_0000_0000_0000);
    send_req(KIND_INSERT, 64'h5555_5555_5555_5555);
    send_req(KIND_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
    send_req(KIND_INSERT, '1);
    send_req(KIND_INSERT, 64'd1);
    send_req(KIND_REMOVE, 64'd1);
    send_req(KIND_REMOVE, 64'd1);
    send_req(KIND_INSERT, 64'd1);
    send_req(KIND_REMOVE, '1);
    send_req(KIND_REMOVE, 64'h8000_0000_0000_0000);
    send_req(KIND_REMOVE, 64'h5555_5555_5555_5555);
    send_req(KIND_REMOVE, 64'hAAAA_AAAA_AAAA_AAAA);
    send_req(KIND_REMOVE, 64'd1);
    wait_idle();

    // random traffic at moderate load
    repeat (450) begin
      r = $urandom_range(0, 99);
      if (r < 3) send_req(kind_t'($urandom_range(0, 1)), '0);
      else if (r < 8) send_req(KIND_REMOVE, rand_key());
      else if (r < 13 && held_keys.size() > 0) insert_held();
      else if (held_keys.size() > 0 && (r < 45 || held_keys.size() > 500)) remove_held();
      else insert_new();
    end

    // fill until every slot is taken; clusters grow long and wrap
    while (held_keys.size() < TABLE_DEPTH) begin
      r = $urandom_range(0, 99);
      if (r < 2) send_req(kind_t'($urandom_range(0, 1)), '0);
      else if (r < 5) send_req(KIND_REMOVE, rand_key());
      else if (r < 8 && held_keys.size() > 0) insert_held();
      else if (r < 11 && held_keys.size() > 0) remove_held();
      else insert_new();
    end
    wait_idle();

    // full table: failed inserts, misses that probe every slot, hits
    repeat (3) insert_new();
    repeat (3) send_req(KIND_REMOVE, rand_key());
    repeat (2) insert_held();
    send_req(KIND_REMOVE, '0);

    // partial drain; the first removes repair a cluster spanning the table
    repeat (40) begin
      if ($urandom_range(0, 99) < 80) remove_held();
      else insert_new();
    end

    wait_idle();
    repeat (64) @(negedge clk);
    if (fail_count == 0) begin
      $display("[linear_probe_key_table] OK");
    end else begin
      $display("[linear_probe_key_table] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/lpkt_pkg.sv
sv/lpkt_ram.sv
sv/lpkt_hash.sv
sv/linear_probe_key_table.sv
sv/lpkt_checker.sv
tb/linear_probe_key_table_checker.sv
tb/linear_probe_key_table_tb.sv
